>>> hdl/qcmr_pkg.sv
// ----------------------------------------------------------------------------
// qcmr_pkg
// Shared types and constants for the quantized convolution MAC/requantizer.
// ----------------------------------------------------------------------------
package qcmr_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned ScaleSh  = 16;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_INPUT_OFFSET  = 3'd0,
    REG_FILTER_OFFSET = 3'd1,
    REG_OUTPUT_OFFSET = 3'd2,
    REG_OUTPUT_MULT   = 3'd3,
    REG_OUTPUT_SHIFT  = 3'd4,
    REG_ACT_MIN       = 3'd5,
    REG_ACT_MAX       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  input_offset;
    logic [8:0]  filter_offset;
    logic [8:0]  output_offset;
    logic [15:0] output_multiplier;
    logic [4:0]  output_shift;
    logic [7:0]  activation_min;
    logic [7:0]  activation_max;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_ACC = 2'd0,
    ST_MUL = 2'd1,
    ST_SHF = 2'd2,
    ST_CLP = 2'd3
  } state_t;

  typedef struct packed {
    logic tap_acc;   // non-last tap transfer: accumulate
    logic tap_last;  // last tap transfer: add bias, capture sum, clear acc
    logic mul;       // scale by output multiplier
    logic shf;       // rounding right shift
    logic out_load;  // offset, clamp, load output register
  } dp_cmd_t;

endpackage

>>> hdl/quantized_conv_mac_requantize.sv
// Throughput: one tap per cycle for taps not marked last; a last tap holds
//   the input through the scale, rounding shift and clamp steps on one
//   shared datapath.
// Output: after a last-tap transfer the clamp step loads the output register and
//   raises out_tvalid; it waits while the previous result is still held there.
// Reset (rst_n low, synchronous): accumulator and out_tvalid cleared, registers 0, activation_max 255.
// ----------------------------------------------------------------------------
// quantized_conv_mac_requantize
// uint8 quantized convolution tap MAC with requantization to one byte.
// ----------------------------------------------------------------------------
module quantized_conv_mac_requantize
  import qcmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,   // in_value, filter_value, bias_value
  input  logic                in_tuser,   // tap_valid
  input  logic                in_tlast,   // last_tap
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // out_value, raw_sum
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t            cfg;
  dp_cmd_t         cmd;
  logic [7:0]      out_value;
  logic [AccW-1:0] raw_sum;

  qcmr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qcmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  qcmr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (cfg),
    .in_value     (in_tdata[7:0]),
    .filter_value (in_tdata[15:8]),
    .tap_valid    (in_tuser),
    .bias_value   (in_tdata[47:16]),
    .out_value    (out_value),
    .raw_sum      (raw_sum)
  );

  assign out_tdata = {raw_sum, out_value};

endmodule

>>> hdl/qcmr_regs.sv
// ----------------------------------------------------------------------------
// qcmr_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module qcmr_regs
  import qcmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CfgAddrW-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_INPUT_OFFSET:  cfg_nxt.input_offset      = cfg_pwdata[8:0];
        REG_FILTER_OFFSET: cfg_nxt.filter_offset     = cfg_pwdata[8:0];
        REG_OUTPUT_OFFSET: cfg_nxt.output_offset     = cfg_pwdata[8:0];
        REG_OUTPUT_MULT:   cfg_nxt.output_multiplier = cfg_pwdata[15:0];
        REG_OUTPUT_SHIFT:  cfg_nxt.output_shift      = cfg_pwdata[4:0];
        REG_ACT_MIN:       cfg_nxt.activation_min    = cfg_pwdata[7:0];
        REG_ACT_MAX:       cfg_nxt.activation_max    = cfg_pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{activation_max: 8'hFF, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_INPUT_OFFSET:  cfg_prdata = {23'd0, cfg_r.input_offset};
      REG_FILTER_OFFSET: cfg_prdata = {23'd0, cfg_r.filter_offset};
      REG_OUTPUT_OFFSET: cfg_prdata = {23'd0, cfg_r.output_offset};
      REG_OUTPUT_MULT:   cfg_prdata = {16'd0, cfg_r.output_multiplier};
      REG_OUTPUT_SHIFT:  cfg_prdata = {27'd0, cfg_r.output_shift};
      REG_ACT_MIN:       cfg_prdata = {24'd0, cfg_r.activation_min};
      REG_ACT_MAX:       cfg_prdata = {24'd0, cfg_r.activation_max};
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

>>> hdl/qcmr_ctrl.sv
// ----------------------------------------------------------------------------
// qcmr_ctrl
// Sequencer: tap accumulation, then three requantization steps per output.
// ----------------------------------------------------------------------------
module qcmr_ctrl
  import qcmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   in_xfer;

  assign out_free   = ~out_valid_r | out_tready;
  assign in_tready  = (state_r == ST_ACC);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: if (in_xfer && in_tlast) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_SHF;
      ST_SHF: state_nxt = ST_CLP;
      ST_CLP: if (out_free) state_nxt = ST_ACC;
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_ACC: begin
        cmd.tap_acc  = in_xfer & ~in_tlast;
        cmd.tap_last = in_xfer & in_tlast;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_SHF: cmd.shf = 1'b1;
      ST_CLP: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/qcmr_dp.sv
// ----------------------------------------------------------------------------
// qcmr_dp
// Datapath: tap MAC, bias add, scale, rounding shift, offset and clamp.
// ----------------------------------------------------------------------------
module qcmr_dp
  import qcmr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  input  cfg_t            cfg,
  input  logic [7:0]      in_value,
  input  logic [7:0]      filter_value,
  input  logic            tap_valid,
  input  logic [AccW-1:0] bias_value,
  output logic [7:0]      out_value,
  output logic [AccW-1:0] raw_sum
);

  logic [AccW-1:0]        acc_r, acc_nxt;
  logic [AccW-1:0]        sum_r;
  logic [ProdW-1:0]       prod_r;
  logic [AccW-1:0]        shr_r;
  logic                   rnd_r;
  logic [7:0]             out_value_r;
  logic [AccW-1:0]        raw_sum_r;

  logic [9:0]             fil_s, inv_s;
  logic signed [19:0]     tap_prod;
  logic [AccW-1:0]        tap_term;
  logic [AccW-1:0]        acc_sum;
  logic signed [48:0]     scaled;
  logic [AccW-1:0]        xx;
  logic [AccW-1:0]        mask;
  logic [AccW-1:0]        thresh;
  logic [AccW-1:0]        shr;
  logic [AccW-1:0]        v;
  logic [7:0]             clamped;

  // 10-bit signed operands: byte plus 9-bit signed offset
  assign fil_s    = {2'b00, filter_value} + {cfg.filter_offset[8], cfg.filter_offset};
  assign inv_s    = {2'b00, in_value} + {cfg.input_offset[8], cfg.input_offset};
  assign tap_prod = $signed(fil_s) * $signed(inv_s);
  assign tap_term = tap_valid ? {{(AccW-20){tap_prod[19]}}, tap_prod} : '0;
  assign acc_sum  = acc_r + tap_term;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.tap_acc) begin
      acc_nxt = acc_sum;
    end else if (cmd.tap_last) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Scale: arithmetic shift of the product gives the floor
  assign scaled = $signed(sum_r) * $signed({1'b0, cfg.output_multiplier});
  assign xx     = prod_r[ProdW-1:ScaleSh];

  // Rounding shift: round up when remainder exceeds half, ties away from zero
  // for sums of either sign
  assign mask   = ~({AccW{1'b1}} << cfg.output_shift);
  assign thresh = (mask >> 1) + {{(AccW-1){1'b0}}, sum_r[AccW-1]};
  assign shr    = $unsigned($signed(xx) >>> cfg.output_shift);

  assign v = shr_r + {{(AccW-1){1'b0}}, rnd_r}
           + {{(AccW-9){cfg.output_offset[8]}}, cfg.output_offset};

  always_comb begin
    if ($signed(v) < $signed({24'd0, cfg.activation_min})) begin
      clamped = cfg.activation_min;
    end else if ($signed(v) > $signed({24'd0, cfg.activation_max})) begin
      clamped = cfg.activation_max;
    end else begin
      clamped = v[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_last) begin
      sum_r <= acc_sum + bias_value;
    end
    if (cmd.mul) begin
      prod_r <= scaled[ProdW-1:0];
    end
    if (cmd.shf) begin
      shr_r <= shr;
      rnd_r <= (xx & mask) > thresh;
    end
    if (cmd.out_load) begin
      out_value_r <= clamped;
      raw_sum_r   <= sum_r;
    end
  end

  assign out_value = out_value_r;
  assign raw_sum   = raw_sum_r;

endmodule

>>> hdl/qcmr_checker.sv
// ----------------------------------------------------------------------------
// qcmr_checker
// Port-level checks for the quantized convolution MAC/requantizer.
// ----------------------------------------------------------------------------
module qcmr_checker
  import qcmr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // Last-tap transfer blocks input while requantizing
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken during requantization");

  // A new result appears only after a requantization sequence has blocked the input
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready, 1) && !$past(in_tready, 2))
    else $error("result without requantization sequence");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind quantized_conv_mac_requantize qcmr_checker u_qcmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
